>>> rtl/neighbourhood_difference_descriptor_macros.svh
// assertion macros for the neighbourhood difference descriptor
// expects clk and rst_n in the scope where a macro is used
`ifndef NEIGHBOURHOOD_DIFFERENCE_DESCRIPTOR_MACROS_SVH
`define NEIGHBOURHOOD_DIFFERENCE_DESCRIPTOR_MACROS_SVH

// antecedent in the same cycle implies consequent
`define NDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// value stays below a limit whenever en is high
`define NDD_ASSERT_BELOW(lbl, en, val, lim, msg) \
    `NDD_ASSERT_IMP(lbl, en, (val) < (lim), msg)

`endif

>>> rtl/ndd_pkg.sv
// shared constants, codes and structs of the neighbourhood difference descriptor
// no dependencies
package ndd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_RADIUS  = 3;
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int PIX_W     = 8;
    localparam int DIFF_W    = 9;
    localparam int CH_W      = 6;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int RAD_W     = 2;
    localparam int LAG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int OFS_W     = 3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PIX_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] difference;
        logic [CH_W-1:0]          channel;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     last;
    } out_entry_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } buf_stat_t;

endpackage

>>> rtl/ndd_line_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ndd_line_ram #(
    parameter int DEPTH  = 7168,
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/ndd_out_buf.sv
// two-entry output buffer: head register drives the result channel, skid behind it
// depends on ndd_pkg
module ndd_out_buf import ndd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  out_entry_t push_entry,
    input  logic       out_stall,
    output logic       out_valid,
    output out_entry_t head,
    output buf_stat_t  buf_stat
);

    logic       head_valid_reg;
    logic       skid_valid_reg;
    out_entry_t head_reg;
    out_entry_t skid_reg;
    logic       pop;

    assign pop        = head_valid_reg && !out_stall;
    assign out_valid  = head_valid_reg;
    assign head       = head_reg;
    assign buf_stat.count = {1'b0, head_valid_reg} + {1'b0, skid_valid_reg};
    assign buf_stat.pop   = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (push && pop)
            begin
                if (skid_valid_reg)
                begin
                    head_reg <= skid_reg;
                    skid_reg <= push_entry;
                end
                else
                begin
                    head_reg <= push_entry;
                end
            end
            else if (push)
            begin
                if (!head_valid_reg)
                begin
                    head_reg       <= push_entry;
                    head_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= push_entry;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                head_reg       <= skid_reg;
                head_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= head_valid_reg;
            end
        end
    end

endmodule

>>> rtl/ndd_seq.sv
// frame counters, config registers and the read sequencer over the line ram
// depends on ndd_pkg
module ndd_seq import ndd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [PIX_W-1:0]     pixel_value,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [PIX_W-1:0]     rd_data,
    input  buf_stat_t            buf_stat,
    output ram_req_t             ram_req,
    output logic                 push,
    output out_entry_t           push_entry
);

    typedef enum logic {S_IDLE, S_EMIT} state_t;

    typedef struct packed {
        logic             valid;
        logic             nb;
        logic [CH_W-1:0]  ch;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } rd_meta_t;

    // config
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [LAG_W-1:0] lag;
    logic             cfg_hit;

    // frame counters
    logic [POS_W-1:0]  write_col_reg, write_col_next;
    logic [DIM_W-1:0]  write_row_reg, write_row_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next;
    logic [POS_W-1:0]  out_row_reg, out_row_next;
    logic [LAG_W-1:0]  lag_count_reg, lag_count_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    // current centre
    logic [POS_W-1:0]  cen_row_reg;
    logic [POS_W-1:0]  cen_col_reg;
    logic [ADDR_W-1:0] cen_addr_reg;
    logic [PIX_W-1:0]  centre_reg;

    // sequencer
    state_t                   state_reg;
    logic signed [OFS_W-1:0]  dy_reg;
    logic signed [OFS_W-1:0]  dx_reg;
    logic [CH_W-1:0]          ch_reg;
    rd_meta_t                 rd_meta_reg;

    logic accept;
    logic frame_full;
    logic do_write;
    logic do_emit;
    logic issue;
    logic last_ch;
    logic inflight;
    logic [2:0] occ;
    logic signed [OFS_W-1:0] r_s;
    logic signed [OFS_W-1:0] dy_adv;
    logic signed [OFS_W-1:0] dx_adv;
    logic [ADDR_W-1:0] nb_addr;

    // effective register values
    assign w_eff = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign r_eff = (radius_reg == '0) ? RAD_W'(1) :
                   (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
    assign lag   = LAG_W'(LAG_W'(r_eff) * LAG_W'(w_eff)) + LAG_W'(r_eff);
    assign r_s   = $signed({1'b0, r_eff});

    assign cfg_hit = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
                                (cfg_index == REG_RADIUS));

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign frame_full = (write_row_reg >= h_eff);
    assign do_write   = accept && (req_type == REQ_PIXEL) && !frame_full;
    assign do_emit    = (do_write && (lag_count_reg >= lag)) ||
                        (accept && (req_type == REQ_FLUSH) && frame_full);

    always_comb
    begin
        logic [DIM_W-1:0] col_inc;
        logic [DIM_W-1:0] ocol_inc;
        logic [DIM_W-1:0] orow_inc;
        write_col_next = write_col_reg;
        write_row_next = write_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        lag_count_next = lag_count_reg;
        wr_addr_next   = wr_addr_reg;
        out_addr_next  = out_addr_reg;
        col_inc  = {1'b0, write_col_reg} + DIM_W'(1);
        ocol_inc = {1'b0, out_col_reg} + DIM_W'(1);
        orow_inc = {1'b0, out_row_reg} + DIM_W'(1);
        if (do_write)
        begin
            wr_addr_next = (wr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0 :
                           wr_addr_reg + ADDR_W'(1);
            if (col_inc >= w_eff)
            begin
                write_col_next = '0;
                write_row_next = write_row_reg + DIM_W'(1);
            end
            else
            begin
                write_col_next = col_inc[POS_W-1:0];
            end
            if (lag_count_reg < lag)
            begin
                lag_count_next = lag_count_reg + LAG_W'(1);
            end
        end
        if (do_emit)
        begin
            out_addr_next = (out_addr_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0 :
                            out_addr_reg + ADDR_W'(1);
            if (ocol_inc >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = orow_inc[POS_W-1:0];
                // last centre of the frame: start over
                if (orow_inc >= h_eff)
                begin
                    write_col_next = '0;
                    write_row_next = '0;
                    out_col_next   = '0;
                    out_row_next   = '0;
                    lag_count_next = '0;
                    wr_addr_next   = '0;
                    out_addr_next  = '0;
                end
            end
            else
            begin
                out_col_next = ocol_inc[POS_W-1:0];
            end
        end
        if (cfg_hit)
        begin
            write_col_next = '0;
            write_row_next = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            lag_count_next = '0;
            wr_addr_next   = '0;
            out_addr_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            radius_reg    <= RAD_W'(1);
            write_col_reg <= '0;
            write_row_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            lag_count_reg <= '0;
            wr_addr_reg   <= '0;
            out_addr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                    default:    width_reg  <= width_reg;
                endcase
            end
            write_col_reg <= write_col_next;
            write_row_reg <= write_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            lag_count_reg <= lag_count_next;
            wr_addr_reg   <= wr_addr_next;
            out_addr_reg  <= out_addr_next;
        end
    end

    // neighbour address: centre address plus clamped offset, wrapped into the ring
    always_comb
    begin
        logic signed [DIM_W:0]   ny_raw;
        logic signed [DIM_W:0]   nx_raw;
        logic signed [DIM_W:0]   ny;
        logic signed [DIM_W:0]   nx;
        logic signed [DIM_W:0]   dyc_full;
        logic signed [DIM_W:0]   dxc_full;
        logic signed [14:0]      dyc_ext;
        logic signed [14:0]      dxc_ext;
        logic signed [14:0]      w_s;
        logic signed [14:0]      row_off;
        logic signed [14:0]      addr_sum;
        ny_raw = $signed({2'b00, cen_row_reg}) + (DIM_W + 1)'(dy_reg);
        nx_raw = $signed({2'b00, cen_col_reg}) + (DIM_W + 1)'(dx_reg);
        priority if (ny_raw < 0)
            ny = '0;
        else if (ny_raw > $signed({1'b0, h_eff - DIM_W'(1)}))
            ny = $signed({1'b0, h_eff - DIM_W'(1)});
        else
            ny = ny_raw;
        priority if (nx_raw < 0)
            nx = '0;
        else if (nx_raw > $signed({1'b0, w_eff - DIM_W'(1)}))
            nx = $signed({1'b0, w_eff - DIM_W'(1)});
        else
            nx = nx_raw;
        dyc_full = ny - $signed({2'b00, cen_row_reg});
        dxc_full = nx - $signed({2'b00, cen_col_reg});
        dyc_ext  = 15'($signed(dyc_full[OFS_W-1:0]));
        dxc_ext  = 15'($signed(dxc_full[OFS_W-1:0]));
        w_s      = $signed({4'b0000, w_eff});
        row_off  = dyc_ext * w_s;
        addr_sum = $signed({2'b00, cen_addr_reg}) + row_off + dxc_ext;
        priority if (addr_sum < 0)
            nb_addr = ADDR_W'(addr_sum + 15'(STORE_DEPTH));
        else if (addr_sum >= 15'(STORE_DEPTH))
            nb_addr = ADDR_W'(addr_sum - 15'(STORE_DEPTH));
        else
            nb_addr = ADDR_W'(addr_sum);
    end

    // next offset in row-major order, centre skipped
    always_comb
    begin
        if (dx_reg == r_s)
        begin
            dx_adv = -r_s;
            dy_adv = dy_reg + OFS_W'(1);
        end
        else
        begin
            dx_adv = dx_reg + OFS_W'(1);
            dy_adv = dy_reg;
        end
        if ((dy_adv == '0) && (dx_adv == '0))
        begin
            dx_adv = OFS_W'(1);
        end
    end

    assign last_ch  = (dy_reg == r_s) && (dx_reg == r_s);
    assign inflight = rd_meta_reg.valid && rd_meta_reg.nb;
    // buffer occupancy after this cycle's pop, counting the read still in flight
    assign occ      = {1'b0, buf_stat.count} + {2'b00, inflight} - {2'b00, buf_stat.pop};
    assign issue    = (state_reg == S_EMIT) && (occ < 3'd2);

    assign ram_req.wr_en   = do_write;
    assign ram_req.wr_addr = wr_addr_reg;
    assign ram_req.wr_data = pixel_value;
    assign ram_req.rd_en   = do_emit || issue;
    assign ram_req.rd_addr = do_emit ? out_addr_reg : nb_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            dy_reg      <= '0;
            dx_reg      <= '0;
            ch_reg      <= '0;
            rd_meta_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (do_emit)
                    begin
                        state_reg         <= S_EMIT;
                        dy_reg            <= -r_s;
                        dx_reg            <= -r_s;
                        ch_reg            <= '0;
                        rd_meta_reg.valid <= 1'b1;
                        rd_meta_reg.nb    <= 1'b0;
                    end
                    else
                    begin
                        rd_meta_reg.valid <= 1'b0;
                    end
                end
                S_EMIT:
                begin
                    if (issue)
                    begin
                        rd_meta_reg.valid <= 1'b1;
                        rd_meta_reg.nb    <= 1'b1;
                        rd_meta_reg.ch    <= ch_reg;
                        rd_meta_reg.last  <= last_ch;
                        rd_meta_reg.row   <= cen_row_reg;
                        rd_meta_reg.col   <= cen_col_reg;
                        dy_reg            <= dy_adv;
                        dx_reg            <= dx_adv;
                        ch_reg            <= ch_reg + CH_W'(1);
                        if (last_ch)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        rd_meta_reg.valid <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg         <= S_IDLE;
                    rd_meta_reg.valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            cen_row_reg  <= out_row_reg;
            cen_col_reg  <= out_col_reg;
            cen_addr_reg <= out_addr_reg;
        end
        if (rd_meta_reg.valid && !rd_meta_reg.nb)
        begin
            centre_reg <= rd_data;
        end
    end

    assign push                  = inflight;
    assign push_entry.difference = $signed({1'b0, centre_reg} - {1'b0, rd_data});
    assign push_entry.channel    = rd_meta_reg.ch;
    assign push_entry.row        = rd_meta_reg.row;
    assign push_entry.col        = rd_meta_reg.col;
    assign push_entry.last       = rd_meta_reg.last;

endmodule

>>> rtl/neighbourhood_difference_descriptor.sv
// top level of the neighbourhood difference descriptor
// depends on ndd_pkg, ndd_line_ram, ndd_seq, ndd_out_buf and the macros header
//
// Input channel (in_valid/in_stall): req_type 0 carries the next raster pixel,
// req_type 1 is a flush step after the frame is complete. Each accepted pixel is
// written into a ring of 2*MAX_RADIUS+1 lines; once R rows plus R pixels are held,
// every pixel (and afterwards every flush step) yields the (2R+1)^2-1 differences
// of one centre pixel, one transaction per result, row-major offsets, clamped
// borders, last_of_pixel on the final one.
// Sequence: the centre is read as the item is accepted, then one ram read per
// neighbour follows, the single read port of the line ram being the limit. The
// first result follows the centre read, its neighbour read and the output head.
// Output channel (out_valid/out_stall): a two-entry buffer holds results; a stall
// pauses the ram reads, and in_stall stays high until the last read is issued.
// Reset: counters clear, registers return to 640 x 480, radius 1; the line ram is
// not cleared since no entry is read before a pixel writes it.
// Configuration writes (cfg_we) to width, height or radius restart the frame;
// the user is to make them while idle, which the block does not enforce.
`include "neighbourhood_difference_descriptor_macros.svh"

module neighbourhood_difference_descriptor import ndd_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [PIX_W-1:0]            pixel_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DIFF_W-1:0]    difference,
    output logic [CH_W-1:0]             channel_index,
    output logic [POS_W-1:0]            centre_row,
    output logic [POS_W-1:0]            centre_col,
    output logic                        last_of_pixel,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DIM_W-1:0]            cfg_data
);

    ram_req_t         ram_req;
    logic [PIX_W-1:0] rd_data;
    buf_stat_t        buf_stat;
    logic             push;
    out_entry_t       push_entry;
    out_entry_t       head;

    ndd_line_ram #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (PIX_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    ndd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_value (pixel_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rd_data     (rd_data),
        .buf_stat    (buf_stat),
        .ram_req     (ram_req),
        .push        (push),
        .push_entry  (push_entry)
    );

    ndd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .head       (head),
        .buf_stat   (buf_stat)
    );

    assign difference    = head.difference;
    assign channel_index = head.channel;
    assign centre_row    = head.row;
    assign centre_col    = head.col;
    assign last_of_pixel = head.last;

    // read credits must keep the output buffer from overflowing
    `NDD_ASSERT_IMP(a_buf_no_overflow, push, (buf_stat.count != 2'd2) || buf_stat.pop,
        "result pushed into a full output buffer")
    // ring wrap of the neighbour address
    `NDD_ASSERT_BELOW(a_rd_addr_range, ram_req.rd_en, ram_req.rd_addr, ADDR_W'(STORE_DEPTH),
        "line ram read address beyond the ring")
    `NDD_ASSERT_BELOW(a_wr_addr_range, ram_req.wr_en, ram_req.wr_addr, ADDR_W'(STORE_DEPTH),
        "line ram write address beyond the ring")

endmodule

>>> test/neighbourhood_difference_descriptor_tb.sv
// testbench for neighbourhood_difference_descriptor: an opening script of directed steps,
// then random frames in several idle and stall mixes, checked by pinned data or a predictor
// depends on ndd_pkg and the neighbourhood_difference_descriptor rtl
module neighbourhood_difference_descriptor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ndd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int MAX_CHANNELS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 40;
    localparam int IN_IDLE_PCT [4]   = '{0, 65, 0, 12};
    localparam int OUT_STALL_PCT [4] = '{0, 0, 65, 12};

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_FLUSH,
        STEP_CONFIG
    } step_kind_t;

    // pinned steps carry their expected results typed in: pin_count differences of pin_diff
    // for the first centre of the frame
    typedef struct packed {
        step_kind_t               kind;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [DIM_W-1:0]         value;
        logic                     pinned;
        logic [6:0]               pin_count;
        logic signed [DIFF_W-1:0] pin_diff;
    } script_step_t;

    localparam script_step_t OPENING [37] = '{
        // default 640 x 480 frame is still filling its lag
        '{STEP_PIXEL,  '0,         11'h0A5, 1'b1, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b1, 7'd0,  9'sd0},
        // single pixel frame at the largest radius: every neighbour clamps onto the centre
        '{STEP_CONFIG, REG_WIDTH,  11'd1,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_HEIGHT, 11'd1,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_RADIUS, 11'd3,   1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h05A, 1'b1, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h0FF, 1'b1, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b1, 7'd48, 9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b1, 7'd0,  9'sd0},
        // zero registers act as width 1, height 1, radius 1
        '{STEP_CONFIG, REG_WIDTH,  11'd0,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_HEIGHT, 11'd0,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_RADIUS, 11'd0,   1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h000, 1'b1, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b1, 7'd8,  9'sd0},
        // two pixel row of full scale and zero; the spare index must not restart the frame
        '{STEP_CONFIG, REG_WIDTH,  11'd2,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_HEIGHT, 11'd1,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_RADIUS, 11'd1,   1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h0FF, 1'b1, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_SPARE,  11'h7FF, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h000, 1'b1, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        // 3 x 2 frame at radius 2, clamped on both axes
        '{STEP_CONFIG, REG_WIDTH,  11'd3,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_HEIGHT, 11'd2,   1'b0, 7'd0,  9'sd0},
        '{STEP_CONFIG, REG_RADIUS, 11'd2,   1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h0FF, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h080, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h07F, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h001, 1'b0, 7'd0,  9'sd0},
        '{STEP_PIXEL,  '0,         11'h0FE, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0},
        '{STEP_FLUSH,  '0,         11'h000, 1'b0, 7'd0,  9'sd0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     req_type = REQ_PIXEL;
    logic [PIX_W-1:0]         pixel_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DIFF_W-1:0] difference;
    logic [CH_W-1:0]          channel_index;
    logic [POS_W-1:0]         centre_row;
    logic [POS_W-1:0]         centre_col;
    logic                     last_of_pixel;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DIM_W-1:0]         cfg_data = '0;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int mismatch_count = 0;

    // predictor state
    logic [PIX_W-1:0] pixel_ring [STORE_DEPTH];
    logic [DIM_W-1:0] width_reg = 11'd640;
    logic [DIM_W-1:0] height_reg = 11'd480;
    logic [RAD_W-1:0] radius_reg = 2'd1;
    int               wr_col = 0;
    int               wr_row = 0;
    int               emit_col = 0;
    int               emit_row = 0;
    int               held = 0;
    out_entry_t       centre_results [MAX_CHANNELS];
    out_entry_t       pending_differences [$];

    neighbourhood_difference_descriptor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .difference    (difference),
        .channel_index (channel_index),
        .centre_row    (centre_row),
        .centre_col    (centre_col),
        .last_of_pixel (last_of_pixel),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int top);
        int d;
        d = int'(v);
        if (d < 1)
            d = 1;
        if (d > top)
            d = top;
        return d;
    endfunction

    function automatic int eff_radius();
        int r;
        r = int'(radius_reg);
        if (r < 1)
            r = 1;
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        return r;
    endfunction

    function automatic void clear_frame_position();
        wr_col = 0;
        wr_row = 0;
        emit_col = 0;
        emit_row = 0;
        held = 0;
    endfunction

    function automatic bit frame_full();
        return wr_row >= eff_dim(height_reg, MAX_HEIGHT);
    endfunction

    function automatic void append_expected(input out_entry_t e);
        pending_differences = {pending_differences, e};
    endfunction

    // differences of the next centre, offsets row-major with the centre skipped
    function automatic int emit_centre(input int w, input int h, input int r);
        int n;
        int ny;
        int nx;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] nb;
        n = 0;
        if (emit_row >= h)
            return 0;
        centre = pixel_ring[(emit_row * w + emit_col) % STORE_DEPTH];
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                if (dy != 0 || dx != 0)
                begin
                    ny = emit_row + dy;
                    if (ny < 0)
                        ny = 0;
                    else if (ny > h - 1)
                        ny = h - 1;
                    nx = emit_col + dx;
                    if (nx < 0)
                        nx = 0;
                    else if (nx > w - 1)
                        nx = w - 1;
                    nb = pixel_ring[(ny * w + nx) % STORE_DEPTH];
                    centre_results[n].difference = DIFF_W'(int'(centre) - int'(nb));
                    centre_results[n].channel    = CH_W'(n);
                    centre_results[n].row        = POS_W'(emit_row);
                    centre_results[n].col        = POS_W'(emit_col);
                    centre_results[n].last       = (n + 1 == (2 * r + 1) * (2 * r + 1) - 1);
                    n++;
                end
            end
        end
        emit_col++;
        if (emit_col >= w)
        begin
            emit_col = 0;
            emit_row++;
        end
        if (emit_row >= h)
            clear_frame_position();
        return n;
    endfunction

    function automatic int predict_descriptor(input logic req, input logic [PIX_W-1:0] pix);
        int w;
        int h;
        int r;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        r = eff_radius();
        if (req == REQ_PIXEL)
        begin
            // pixels past a full frame are dropped until the flush drains it
            if (wr_row >= h)
                return 0;
            pixel_ring[(wr_row * w + wr_col) % STORE_DEPTH] = pix;
            wr_col++;
            if (wr_col >= w)
            begin
                wr_col = 0;
                wr_row++;
            end
            if (held < r * w + r)
            begin
                held++;
                return 0;
            end
        end
        else if (wr_row < h)
            return 0;
        return emit_centre(w, h, r);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_differences.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        unique case (index)
            REG_WIDTH:  width_reg = value;
            REG_HEIGHT: height_reg = value;
            REG_RADIUS: radius_reg = value[RAD_W-1:0];
            default:    ;
        endcase
        if (index != REG_SPARE)
            clear_frame_position();
    endtask

    task automatic program_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                 input logic [DIM_W-1:0] r);
        drain_results();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS, r);
    endtask

    task automatic send_item(input logic req, input logic [PIX_W-1:0] pix, input logic pinned,
                             input int pin_count, input logic signed [DIFF_W-1:0] pin_diff);
        int n;
        out_entry_t e;
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (in_stall);
        n = predict_descriptor(req, pix);
        if (pinned)
        begin
            for (int i = 0; i < pin_count; i++)
            begin
                e.difference = pin_diff;
                e.channel    = CH_W'(i);
                e.row        = '0;
                e.col        = '0;
                e.last       = (i == pin_count - 1);
                append_expected(e);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
                append_expected(centre_results[i]);
        end
    endtask

    // whole frames then their flush drain, with a few dropped pixels and early flushes mixed in
    task automatic run_random_frames(input int budget);
        int done;
        bit paused;
        logic [PIX_W-1:0] pix;
        done = 0;
        paused = 1'b0;
        while (done < budget)
        begin
            if (!paused && done >= budget / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(3))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = PIX_W'($urandom_range(255));
            endcase
            if (!frame_full())
            begin
                if ($urandom_range(19) == 0)
                    send_item(REQ_FLUSH, pix, 1'b0, 0, '0);
                send_item(REQ_PIXEL, pix, 1'b0, 0, '0);
            end
            else
            begin
                if ($urandom_range(19) == 0)
                    send_item(REQ_PIXEL, pix, 1'b0, 0, '0);
                send_item(REQ_FLUSH, pix, 1'b0, 0, '0);
            end
            done++;
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin : check_results
        out_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_differences.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d channel %0d",
                                          centre_row, centre_col, channel_index));
            else
            begin
                want = pending_differences.pop_front();
                if (difference !== want.difference)
                    report_mismatch($sformatf(
                        "difference %0d, expected %0d (row %0d col %0d ch %0d)",
                        $signed(difference), $signed(want.difference),
                        want.row, want.col, want.channel));
                if (channel_index !== want.channel)
                    report_mismatch($sformatf("channel_index %0d, expected %0d",
                                              channel_index, want.channel));
                if (centre_row !== want.row)
                    report_mismatch($sformatf("centre_row %0d, expected %0d",
                                              centre_row, want.row));
                if (centre_col !== want.col)
                    report_mismatch($sformatf("centre_col %0d, expected %0d",
                                              centre_col, want.col));
                if (last_of_pixel !== want.last)
                    report_mismatch($sformatf(
                        "last_of_pixel %0b, expected %0b (row %0d col %0d ch %0d)",
                        last_of_pixel, want.last, want.row, want.col, want.channel));
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_pct   = IN_IDLE_PCT[3];
        out_stall_pct = OUT_STALL_PCT[3];
        foreach (OPENING[i])
        begin
            if (OPENING[i].kind == STEP_CONFIG)
            begin
                drain_results();
                write_reg(OPENING[i].reg_index, OPENING[i].value);
            end
            else
                send_item((OPENING[i].kind == STEP_FLUSH) ? REQ_FLUSH : REQ_PIXEL,
                          OPENING[i].value[PIX_W-1:0], OPENING[i].pinned,
                          int'(OPENING[i].pin_count), OPENING[i].pin_diff);
        end

        for (int p = 0; p < 8; p++)
        begin
            in_idle_pct   = IN_IDLE_PCT[p % 4];
            out_stall_pct = OUT_STALL_PCT[p % 4];
            program_frame(DIM_W'($urandom_range(0, 10)), DIM_W'($urandom_range(0, 6)),
                          DIM_W'($urandom_range(0, 3)));
            run_random_frames(44);
            if (p == 3)
            begin
                // over-range size saturates to the largest frame; the lag is never reached
                in_idle_pct   = IN_IDLE_PCT[0];
                out_stall_pct = OUT_STALL_PCT[0];
                program_frame(11'd2047, 11'd2047, 11'd3);
                run_random_frames(40);
                // tallest column, top part of the frame
                in_idle_pct   = IN_IDLE_PCT[3];
                out_stall_pct = OUT_STALL_PCT[3];
                program_frame(11'd1, 11'd1024, 11'd1);
                run_random_frames(40);
            end
        end

        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("neighbourhood_difference_descriptor verification clean");
        else
            $display("neighbourhood_difference_descriptor verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("neighbourhood_difference_descriptor verification failed");
        $finish;
    end

endmodule
